// File: src/cal_pkg.sv
// Shared constants for the compacting array list core.
`timescale 1ns / 1ps

package cal_pkg;

	// Entry word width and default list capacity.
	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 64;

	// Widths of the request and result fields.
	localparam int OP_W    = 3;
	localparam int POS_W   = 6;
	localparam int IDX_W   = 7;
	localparam int STAT_W  = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE_POS = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE_VAL = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND       = 3'd3;
	localparam logic [OP_W-1:0] OP_READ       = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

	// Index reported when no entry matches.
	localparam logic [IDX_W-1:0] IDX_NONE = 7'h7F;

endpackage

// File: src/compacting_array_list_core.sv
// Top level: request sequencer, compare unit and result register around the entry RAM.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries, kept packed from index 0.
// A request is taken when start is high and busy is low; its result appears on
// the result ports for exactly one cycle with done high and cannot be held off,
// so the receiver must take it in that cycle. Append, clear, unused codes and
// out-of-range positions finish at the accepting edge (result next cycle, busy
// stays low). A read passes through the registered RAM read port and S_RD_WAIT. Find
// walks the entries through one equality compare, one entry per cycle, until it
// hits or runs past the last entry. A remove adds a shift pass that moves each
// later entry down one place, with the RAM reads and writes overlapped.
// Nothing is cleared after reset; only entries below the count are ever read.
module compacting_array_list_core
	import cal_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic [POS_W-1:0]         position,
	output logic                     done,
	output logic signed [DATA_W-1:0] read_value,
	output logic signed [IDX_W-1:0]  found_index,
	output logic [IDX_W-1:0]         entry_count,
	output logic [STAT_W-1:0]        status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_WAIT,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic [CW-1:0]     scan_i_q;
	logic              chk_v_q;
	logic [AW-1:0]     chk_i_q;
	logic [CW-1:0]     sh_rd_q;
	logic              wr_v_q;
	logic [AW-1:0]     wr_i_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic full;
	logic in_range;
	logic hit;
	logic scan_more;
	logic shift_more;

	assign busy       = (state_q != S_IDLE);
	assign full       = (count_q == CW'(DEPTH));
	assign in_range   = (XW'(position) < XW'(count_q));
	// shared compare unit: the entry just read against the request value
	assign hit        = chk_v_q && (ram_rdata == val_q);
	assign scan_more  = (scan_i_q < count_q);
	assign shift_more = (sh_rd_q < count_q);

	cal_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// RAM port drive
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = item_value;
		ram_re    = 1'b0;
		ram_raddr = AW'(position);
		case (state_q)
			S_IDLE: begin
				if (start && (operation == OP_APPEND) && !full) begin
					ram_we = 1'b1;
				end
				if (start && (operation == OP_READ) && in_range) begin
					ram_re = 1'b1;
				end
			end
			S_SCAN: begin
				ram_raddr = scan_i_q[AW-1:0];
				if (!hit && scan_more) begin
					ram_re = 1'b1;
				end
			end
			S_SHIFT: begin
				ram_waddr = wr_i_q;
				ram_wdata = ram_rdata;
				ram_we    = wr_v_q;
				ram_raddr = sh_rd_q[AW-1:0];
				ram_re    = shift_more;
			end
			default: begin
			end
		endcase
	end

	// sequencer, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			op_q        <= '0;
			val_q       <= '0;
			scan_i_q    <= '0;
			chk_v_q     <= 1'b0;
			chk_i_q     <= '0;
			sh_rd_q     <= '0;
			wr_v_q      <= 1'b0;
			wr_i_q      <= '0;
			done        <= 1'b0;
			read_value  <= '0;
			found_index <= '0;
			entry_count <= '0;
			status      <= STAT_OK;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q        <= operation;
						val_q       <= item_value;
						read_value  <= '0;
						found_index <= IDX_NONE;
						entry_count <= IDX_W'(count_q);
						status      <= STAT_OK;
						case (operation)
							OP_APPEND: begin
								done <= 1'b1;
								if (full) begin
									status <= STAT_FULL;
								end else begin
									count_q     <= count_q + CW'(1);
									entry_count <= IDX_W'(count_q + CW'(1));
								end
							end
							OP_REMOVE_POS: begin
								if (in_range) begin
									sh_rd_q <= CW'(position) + CW'(1);
									wr_v_q  <= 1'b0;
									state_q <= S_SHIFT;
								end else begin
									done   <= 1'b1;
									status <= STAT_RANGE;
								end
							end
							OP_REMOVE_VAL, OP_FIND: begin
								scan_i_q <= '0;
								chk_v_q  <= 1'b0;
								state_q  <= S_SCAN;
							end
							OP_READ: begin
								if (in_range) begin
									state_q <= S_RD_WAIT;
								end else begin
									done   <= 1'b1;
									status <= STAT_RANGE;
								end
							end
							OP_CLEAR: begin
								done        <= 1'b1;
								count_q     <= '0;
								entry_count <= '0;
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end

				// registered read data is ready
				S_RD_WAIT: begin
					done       <= 1'b1;
					read_value <= ram_rdata;
					state_q    <= S_IDLE;
				end

				// one entry compared per cycle, next address issued alongside
				S_SCAN: begin
					if (hit) begin
						found_index <= IDX_W'(chk_i_q);
						if (op_q == OP_FIND) begin
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							sh_rd_q <= CW'(chk_i_q) + CW'(1);
							wr_v_q  <= 1'b0;
							state_q <= S_SHIFT;
						end
					end else if (scan_more) begin
						chk_v_q  <= 1'b1;
						chk_i_q  <= scan_i_q[AW-1:0];
						scan_i_q <= scan_i_q + CW'(1);
					end else begin
						done    <= 1'b1;
						status  <= STAT_MISSING;
						state_q <= S_IDLE;
					end
				end

				// move entry i+1 down to i, read and write overlapped
				S_SHIFT: begin
					if (shift_more) begin
						wr_v_q  <= 1'b1;
						wr_i_q  <= AW'(sh_rd_q - CW'(1));
						sh_rd_q <= sh_rd_q + CW'(1);
					end else begin
						wr_v_q      <= 1'b0;
						count_q     <= count_q - CW'(1);
						entry_count <= IDX_W'(count_q - CW'(1));
						done        <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/cal_ram.sv
// Entry storage: one write port, one registered read port.
`timescale 1ns / 1ps

module cal_ram
	import cal_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered: data follows the address in the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
